@@ design/spq_pkg.sv @@
// Package for the sorted priority queue: field widths, codes and struct types.
package spq_pkg;

  localparam int DataW     = 16;
  localparam int PrioW     = 8;
  localparam int CountOutW = 5;
  localparam int DepthDef  = 16;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

  // operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_ROT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REMOVE = 2'b10
  } state_t;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [DataW-1:0] data;
  } entry_t;

  typedef struct packed {
    logic   vld;
    entry_t ent;
  } slot_t;

  typedef struct packed {
    op_t    op;
    entry_t ins;
    logic   keep;
  } cell_ctrl_t;

  typedef struct packed {
    cmd_t             command;
    logic [DataW-1:0] item_data;
    logic [PrioW-1:0] item_priority;
  } in_req_t;

  typedef struct packed {
    logic [DataW-1:0]     popped_data;
    logic                 head_valid;
    logic [DataW-1:0]     head_data;
    logic [PrioW-1:0]     head_priority;
    logic [CountOutW-1:0] occupancy;
    logic [CountOutW-1:0] removed_count;
    err_t                 error_code;
  } out_rsp_t;

endpackage

@@ design/spq_cell.sv @@
// One queue slot: holds an entry and trades it with its neighbors as the broadcast operation directs.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  slot_t      prev,
  input  logic       prev_stays,
  input  slot_t      next,
  output slot_t      cur,
  output logic       stays,
  output slot_t      cur_nxt
);

  logic   vld_r, vld_nxt;
  entry_t ent_r, ent_nxt;

  // entry keeps its place on push: it ranks equal or above the new one
  assign stays = vld_r && (ent_r.prio >= ctrl.ins.prio);

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    case (ctrl.op)
      OP_HOLD: begin
      end
      OP_PUSH: begin
        if (!stays) begin
          if (prev_stays) begin
            vld_nxt = 1'b1;
            ent_nxt = ctrl.ins;
          end else begin
            vld_nxt = prev.vld;
            ent_nxt = prev.ent;
          end
        end
      end
      OP_POP: begin
        vld_nxt = next.vld;
        ent_nxt = next.ent;
      end
      OP_CLEAR: begin
        vld_nxt = 1'b0;
      end
      OP_ROT: begin
        // shift toward head; the old head re-enters at the tail if kept
        if (next.vld) begin
          vld_nxt = 1'b1;
          ent_nxt = next.ent;
        end else if (vld_r) begin
          vld_nxt = ctrl.keep;
          ent_nxt = ctrl.ins;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign cur     = '{vld: vld_r, ent: ent_r};
  assign cur_nxt = '{vld: vld_nxt, ent: ent_nxt};

endmodule

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: cell chain, command control, result register.
//
//   channel | ports                      | carries
//   --------+----------------------------+-----------------------------------
//   input   | in_valid, in_stall, in_req  | command, item_data, item_priority
//   output  | out_valid, out_stall, out_rsp| head, occupancy, counts, error
//
// Push, pop and clear load the result as they are taken; a remove first latches
// the priority, then rotates each held entry through the head cell to be kept or
// dropped, and last loads the result.
// The result is registered; the next request is taken once that register frees.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// A stalled result holds and stalls the input side.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DepthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    iter_r, iter_nxt;
  logic [CW-1:0]    removed_r, removed_nxt;
  logic [PrioW-1:0] rm_prio_r, rm_prio_nxt;
  out_rsp_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  cell_ctrl_t       ctrl;
  slot_t            cur [DEPTH];
  slot_t            cur_nxt [DEPTH];
  logic             stays [DEPTH];
  logic [DEPTH-1:0] vld_vec;

  logic             in_acc, full, empty, load, keep;
  err_t             err;
  logic [DataW-1:0] popped;
  slot_t            hd;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t prev_s, next_s;
    logic  prev_st;
    if (i == 0) begin : g_first
      assign prev_s  = '0;
      assign prev_st = 1'b1;
    end else begin : g_mid
      assign prev_s  = cur[i-1];
      assign prev_st = stays[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_body
      assign next_s = cur[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev       (prev_s),
      .prev_stays (prev_st),
      .next       (next_s),
      .cur        (cur[i]),
      .stays      (stays[i]),
      .cur_nxt    (cur_nxt[i])
    );
    assign vld_vec[i] = cur[i].vld;
  end

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign keep     = cur[0].ent.prio != rm_prio_r;
  assign hd       = cur_nxt[0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    iter_nxt      = iter_r;
    removed_nxt   = removed_r;
    rm_prio_nxt   = rm_prio_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl.op       = OP_HOLD;
    ctrl.ins      = '{prio: in_req.item_priority, data: in_req.item_data};
    ctrl.keep     = 1'b0;
    err           = ERR_OK;
    popped        = '0;
    load          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req.command)
            CMD_PUSH: begin
              load        = 1'b1;
              removed_nxt = '0;
              if (full) begin
                err = ERR_PUSH_FULL;
              end else begin
                ctrl.op   = OP_PUSH;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP: begin
              load        = 1'b1;
              removed_nxt = '0;
              if (empty) begin
                err = ERR_POP_EMPTY;
              end else begin
                ctrl.op     = OP_POP;
                popped      = cur[0].ent.data;
                count_nxt   = count_r - CW'(1);
                removed_nxt = CW'(1);
              end
            end
            CMD_REMOVE: begin
              state_nxt   = ST_REMOVE;
              iter_nxt    = count_r;
              rm_prio_nxt = in_req.item_priority;
              removed_nxt = '0;
            end
            CMD_CLEAR: begin
              load        = 1'b1;
              ctrl.op     = OP_CLEAR;
              removed_nxt = count_r;
              count_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REMOVE: begin
        if (iter_r != '0) begin
          ctrl.op   = OP_ROT;
          ctrl.ins  = cur[0].ent;
          ctrl.keep = keep;
          iter_nxt  = iter_r - CW'(1);
          if (!keep) begin
            count_nxt   = count_r - CW'(1);
            removed_nxt = removed_r + CW'(1);
          end
        end else begin
          state_nxt = ST_IDLE;
          load      = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_nxt.popped_data   = popped;
      out_nxt.head_valid    = hd.vld;
      out_nxt.head_data     = hd.vld ? hd.ent.data : '0;
      out_nxt.head_priority = hd.vld ? hd.ent.prio : '0;
      out_nxt.occupancy     = CountOutW'(count_nxt);
      out_nxt.removed_count = CountOutW'(removed_nxt);
      out_nxt.error_code    = err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r    <= iter_nxt;
    removed_r <= removed_nxt;
    rm_prio_r <= rm_prio_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("occupancy disagrees with cell valids");

  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, vld_vec} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("cell valids not packed at head");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_req.command == CMD_PUSH) && !full |=>
      count_r == $past(count_r + CW'(1)))
    else $error("push did not grow occupancy");

  a_remove_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REMOVE) && (iter_r == '0) |=> out_valid_r)
    else $error("remove finished without result");
`endif

endmodule
